// File: sv/vtc_pkg.sv
// shared types and constants of the vehicle tour checker
`timescale 1ns / 1ps
`default_nettype none

package vtc_pkg;

    // field widths
    localparam int NODE_W   = 8;
    localparam int DEMAND_W = 16;
    localparam int LOAD_W   = 24;
    localparam int COUNT_W  = 9;
    localparam int ERR_W    = 3;
    localparam int EPOCH_W  = 8;
    localparam int REG_W    = 1;

    // packed stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [DEMAND_W-1:0] demand_t;
    typedef logic [LOAD_W-1:0]   load_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [ERR_W-1:0]    err_t;
    typedef logic [EPOCH_W-1:0]  epoch_t;
    typedef logic [REG_W-1:0]    reg_idx_t;

    // error codes
    localparam err_t ERR_NONE      = 3'd0;
    localparam err_t ERR_NO_DEPOT  = 3'd1;
    localparam err_t ERR_RANGE     = 3'd2;
    localparam err_t ERR_REPEAT    = 3'd3;
    localparam err_t ERR_EMPTY     = 3'd4;
    localparam err_t ERR_OVER_CAP  = 3'd5;
    localparam err_t ERR_UNVISITED = 3'd6;

    // register indexes
    localparam reg_idx_t REG_NODE_COUNT = 1'b0;
    localparam reg_idx_t REG_CAPACITY   = 1'b1;

    localparam load_t  LOAD_MAX        = 24'hFFFFFF;
    localparam count_t NODE_COUNT_RST  = 9'd256;
    localparam node_t  DEPOT           = 8'd0;

    // visited tags: zero is the cleared value, live epochs run 1 up to all ones
    localparam epoch_t EPOCH_FIRST = 8'd1;
    localparam epoch_t EPOCH_LAST  = 8'hFF;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

`default_nettype wire

// File: sv/vtc_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module vtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/vehicle_tour_checker.sv
// top level of the vehicle tour checker
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata: node_index, node_demand; tlast: last_item
//  m_*       out        m_tvalid/m_tready  tdata: error_code, current_load; tlast: tour_done;
//                                          tuser: tour_valid
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
//  one request per cycle unless m_ stalls or the tags clear; items pass lookup stage, result reg
//  the visited map is a ram of epoch tags: one read when a request is taken, one write when it
//  leaves the lookup stage; a write to the same node in the cycle of the read is forwarded
//  after reset, and after every 255th tour, a clearing pass over all MAP_DEPTH tags (at most 256)
//  zeroes the tags; s_tready stays low during it
//  a stalled m_ side holds the result register and the item behind it, then s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module vehicle_tour_checker #(
    parameter int MAX_NODES = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // request stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [vtc_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] node_index, [23:8] node_demand
    input  wire logic                      s_tlast,
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [vtc_pkg::M_DATA_W-1:0] m_tdata,  // [2:0] error_code, [26:3] current_load
    output logic                           m_tlast,
    output logic                           m_tuser,   // [0] tour_valid
    // register writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [vtc_pkg::REG_W-1:0] cfg_index,
    input  wire logic [vtc_pkg::LOAD_W-1:0] cfg_data
);

    import vtc_pkg::*;

    localparam int MAP_DEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAP_DEPTH - 1);
    localparam count_t COUNT_CAP = (MAX_NODES > 511) ? 9'd511 : COUNT_W'(MAX_NODES);

    // configuration
    count_t node_count_reg;
    load_t  capacity_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    epoch_t            epoch_reg;

    // tour state
    load_t  route_load_reg, route_load_next;
    logic   route_open_reg, route_open_next;
    count_t distinct_reg, distinct_next;
    err_t   sticky_err_reg, err_next;
    logic   at_start_reg, at_start_next;

    // lookup stage
    logic    s1_valid_reg;
    node_t   s1_node_reg;
    demand_t s1_demand_reg;
    logic    s1_last_reg;
    logic    fwd_hit_reg;

    // result register
    logic  m_valid_reg;
    err_t  m_err_reg;
    load_t m_load_reg;
    logic  m_done_reg;
    logic  m_ok_reg;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    epoch_t            ram_wdata;
    epoch_t            ram_q;

    logic   s_accept;
    logic   s1_adv;
    logic   wrap_hold;
    logic   map_we;
    logic   visited;
    logic   ok_next;
    count_t eff_count;
    count_t needed;
    logic [LOAD_W:0] load_sum;

    // config port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            capacity_reg   <= LOAD_MAX;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data[COUNT_W-1:0];
                REG_CAPACITY:   capacity_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign wrap_hold = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_LAST);
    assign s_accept  = s_tvalid && s_tready;

    // sequencer: clearing pass and run
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                s_tready = !wrap_hold && (!s1_valid_reg || s1_adv);
                if (s1_adv && wrap_hold) begin
                    state_next    = ST_CLEAR;
                    clr_addr_next = '0;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // visited tag memory
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_adv && map_we;
            ram_waddr = s1_node_reg[ADDR_W-1:0];
            ram_wdata = epoch_reg;
        end
    end

    vtc_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_accept),
        .rd_addr (s_tdata[ADDR_W-1:0]),
        .rd_data (ram_q)
    );

    // lookup stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_node_reg   <= s_tdata[NODE_W-1:0];
            s1_demand_reg <= s_tdata[NODE_W +: DEMAND_W];
            s1_last_reg   <= s_tlast;
            // same node written this cycle within the same tour
            fwd_hit_reg   <= ram_we && (state_reg == ST_RUN) && !s1_last_reg
                             && (ram_waddr == s_tdata[ADDR_W-1:0]);
        end
    end

    // effective node count and customers required
    always_comb begin
        if (node_count_reg > COUNT_CAP) begin
            eff_count = COUNT_CAP;
        end else begin
            eff_count = node_count_reg;
        end
        needed = (eff_count == '0) ? '0 : eff_count - 1'b1;
    end

    assign visited  = fwd_hit_reg || (ram_q == epoch_reg);
    assign load_sum = {1'b0, route_load_reg} + {{(LOAD_W + 1 - DEMAND_W){1'b0}}, s1_demand_reg};

    // tour checks on the item in the lookup stage
    always_comb begin
        err_next        = sticky_err_reg;
        route_load_next = route_load_reg;
        route_open_next = route_open_reg;
        distinct_next   = distinct_reg;
        at_start_next   = at_start_reg;
        map_we          = 1'b0;
        ok_next         = 1'b0;

        if (at_start_reg) begin
            if ((s1_node_reg != DEPOT) && (err_next == ERR_NONE)) begin
                err_next = ERR_NO_DEPOT;
            end
            at_start_next   = 1'b0;
            route_load_next = '0;
            route_open_next = 1'b0;
        end else if (s1_node_reg == DEPOT) begin
            // depot closes the route
            if (err_next == ERR_NONE) begin
                if (!route_open_reg) begin
                    err_next = ERR_EMPTY;
                end else if (route_load_reg > capacity_reg) begin
                    err_next = ERR_OVER_CAP;
                end
            end
            route_load_next = '0;
            route_open_next = 1'b0;
        end else if ({1'b0, s1_node_reg} >= eff_count) begin
            if (err_next == ERR_NONE) begin
                err_next = ERR_RANGE;
            end
        end else if (visited) begin
            if (err_next == ERR_NONE) begin
                err_next = ERR_REPEAT;
            end
        end else begin
            // new customer
            map_we          = 1'b1;
            distinct_next   = distinct_reg + 1'b1;
            route_open_next = 1'b1;
            route_load_next = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
        end

        if (s1_last_reg) begin
            if ((distinct_next != needed) && (err_next == ERR_NONE)) begin
                err_next = ERR_UNVISITED;
            end
            ok_next = (err_next == ERR_NONE);
        end
    end

    // tour state update, cleared at tour end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_load_reg <= '0;
            route_open_reg <= 1'b0;
            distinct_reg   <= '0;
            sticky_err_reg <= ERR_NONE;
            at_start_reg   <= 1'b1;
            epoch_reg      <= EPOCH_FIRST;
        end else if (s1_adv) begin
            if (s1_last_reg) begin
                route_load_reg <= '0;
                route_open_reg <= 1'b0;
                distinct_reg   <= '0;
                sticky_err_reg <= ERR_NONE;
                at_start_reg   <= 1'b1;
                epoch_reg      <= (epoch_reg == EPOCH_LAST) ? EPOCH_FIRST : epoch_reg + 1'b1;
            end else begin
                route_load_reg <= route_load_next;
                route_open_reg <= route_open_next;
                distinct_reg   <= distinct_next;
                sticky_err_reg <= err_next;
                at_start_reg   <= at_start_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_err_reg  <= err_next;
            m_load_reg <= route_load_next;
            m_done_reg <= s1_last_reg;
            m_ok_reg   <= ok_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - ERR_W - LOAD_W){1'b0}}, m_load_reg, m_err_reg};
    assign m_tlast  = m_done_reg;
    assign m_tuser  = m_ok_reg;

endmodule

`default_nettype wire

// File: sv/vtc_checker.sv
// port-level assertions for the vehicle tour checker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module vtc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [vtc_pkg::S_DATA_W-1:0]  s_tdata,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [vtc_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [vtc_pkg::REG_W-1:0]     cfg_index,
    input wire logic [vtc_pkg::LOAD_W-1:0]    cfg_data
);

    import vtc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // a passing tour only on its closing result, with no error
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[ERR_W-1:0] == ERR_NONE))
        else $error("tour_valid without tour end or with error");

    // a clean closing result is always a passing one
    a_clean_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && (m_tdata[ERR_W-1:0] == ERR_NONE) |-> m_tuser)
        else $error("clean tour end not marked valid");

    // the map clearing pass follows reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken right after reset");

endmodule

bind vehicle_tour_checker vtc_checker u_vtc_checker (.*);

`default_nettype wire
